@@ rtl/core/adb_pkg.sv @@
// Shared types, codes and lookup tables for the 4-bit ADPCM byte decoder.
// No dependencies; used by adb_nib_dec, adb_out_reg and adpcm4_byte_decoder_unit.
`default_nettype none

package adb_pkg;

    localparam int SAMPLE_W = 8;
    localparam int NIB_W    = 4;
    localparam int STEP_W   = 2;
    localparam int IDX_W    = STEP_W + NIB_W;
    localparam int TAB_N    = 1 << IDX_W;
    localparam int DELTA_W  = 8;
    localparam int SUM_W    = SAMPLE_W + 2;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MID = 8'd128;
    localparam logic [STEP_W-1:0]   STEP_INIT  = 2'd0;

    // func codes carried on tuser
    localparam logic FUNC_DATA    = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } result_t;

    // Delta per {step, nibble}; bit 3 of the nibble is the sign
    localparam logic signed [DELTA_W-1:0] DELTA_TAB [TAB_N] = '{
        8'sd0,  8'sd1,  8'sd2,  8'sd3,  8'sd4,  8'sd5,  8'sd6,  8'sd7,
        8'sd0, -8'sd1, -8'sd2, -8'sd3, -8'sd4, -8'sd5, -8'sd6, -8'sd7,
        8'sd1,  8'sd3,  8'sd5,  8'sd7,  8'sd9,  8'sd11, 8'sd13, 8'sd15,
        -8'sd1, -8'sd3, -8'sd5, -8'sd7, -8'sd9, -8'sd11, -8'sd13, -8'sd15,
        8'sd2,  8'sd6,  8'sd10, 8'sd14, 8'sd18, 8'sd22, 8'sd26, 8'sd30,
        -8'sd2, -8'sd6, -8'sd10, -8'sd14, -8'sd18, -8'sd22, -8'sd26, -8'sd30,
        8'sd4,  8'sd12, 8'sd20, 8'sd28, 8'sd36, 8'sd44, 8'sd52, 8'sd60,
        -8'sd4, -8'sd12, -8'sd20, -8'sd28, -8'sd36, -8'sd44, -8'sd52, -8'sd60
    };

    localparam logic [STEP_W-1:0] NEXT_TAB [TAB_N] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
        2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2,
        2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3,
        2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3,
        2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
        2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3
    };

endpackage

`default_nettype wire

@@ rtl/core/adpcm4_byte_decoder_unit.sv @@
// 4-bit ADPCM byte decoder, top level: input holding register, decoder state,
// nibble decode (adb_nib_dec) and result register (adb_out_reg). Uses adb_pkg.
//
// Input stream (s_*): tdata = in_byte, tuser = func (0 data, 1 restart).
// Result stream (m_*): tdata = sample, tlast = 1 on the last result of a byte.
// A restart clears the primed flag and produces no result; the first data byte
// after reset or restart goes out unchanged and seeds the reference sample.
// Every later data byte yields two samples, high nibble first.
// A byte's first result passes through the holding register and then the
// result register before it is valid on m_*. A primed data byte issues its
// two samples on the single result port, one sample per cycle while the
// result register can load; a raw byte issues one sample, a restart none.
// The next byte is taken in the same cycle the held one issues its last result.
// When m_tready is low the result register holds, the held byte waits and
// s_tready drops once the holding register cannot drain.
// Reset (aresetn low, synchronous): streams empty, reference 128, step 0,
// not primed.
`default_nettype none

module adpcm4_byte_decoder_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [adb_pkg::SAMPLE_W-1:0] s_tdata,   // [7:0] in_byte
    input  wire logic                         s_tuser,   // [0] func
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [adb_pkg::SAMPLE_W-1:0] m_tdata,   // [7:0] sample
    output logic                              m_tlast
);

    // holding register
    logic                         hold_valid_reg, hold_valid_next;
    logic                         hold_func_reg;
    logic [adb_pkg::SAMPLE_W-1:0] hold_byte_reg;
    logic                         phase_reg, phase_next;   // 1 = low nibble pending

    // decoder state
    logic [adb_pkg::SAMPLE_W-1:0] ref_reg, ref_next;
    logic [adb_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                         primed_reg, primed_next;

    logic                         out_ready;
    logic                         is_restart;
    logic                         hold_fire;
    logic                         item_done;
    logic                         emit;
    logic                         s_xfer;
    logic [adb_pkg::NIB_W-1:0]    nibble;
    logic [adb_pkg::SAMPLE_W-1:0] dec_sample;
    logic [adb_pkg::STEP_W-1:0]   dec_step;
    adb_pkg::result_t             result;

    assign is_restart = (hold_func_reg == adb_pkg::FUNC_RESTART);
    assign hold_fire  = hold_valid_reg && (is_restart || out_ready);
    assign item_done  = is_restart || !primed_reg || phase_reg;
    assign emit       = hold_valid_reg && !is_restart && out_ready;
    assign s_tready   = !hold_valid_reg || (hold_fire && item_done);
    assign s_xfer     = s_tvalid && s_tready;
    assign nibble     = phase_reg ? hold_byte_reg[adb_pkg::NIB_W-1:0]
                                  : hold_byte_reg[adb_pkg::SAMPLE_W-1:adb_pkg::NIB_W];

    adb_nib_dec u_nib_dec (
        .ref_sample (ref_reg),
        .step       (step_reg),
        .nibble     (nibble),
        .sample     (dec_sample),
        .step_next  (dec_step)
    );

    always_comb begin
        result.sample = primed_reg ? dec_sample : hold_byte_reg;
        result.last   = item_done;
    end

    always_comb begin
        hold_valid_next = hold_valid_reg;
        phase_next      = phase_reg;
        ref_next        = ref_reg;
        step_next       = step_reg;
        primed_next     = primed_reg;

        if (hold_fire) begin
            if (is_restart) begin
                primed_next = 1'b0;
            end else if (!primed_reg) begin
                // raw first sample seeds the reference
                ref_next    = hold_byte_reg;
                step_next   = adb_pkg::STEP_INIT;
                primed_next = 1'b1;
            end else begin
                ref_next   = dec_sample;
                step_next  = dec_step;
                phase_next = !phase_reg;
            end
            if (item_done) begin
                hold_valid_next = 1'b0;
                phase_next      = 1'b0;
            end
        end

        if (s_xfer) begin
            hold_valid_next = 1'b1;
            phase_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
            ref_reg        <= adb_pkg::SAMPLE_MID;
            step_reg       <= adb_pkg::STEP_INIT;
            primed_reg     <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
            ref_reg        <= ref_next;
            step_reg       <= step_next;
            primed_reg     <= primed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            hold_byte_reg <= s_tdata;
            hold_func_reg <= s_tuser;
        end
    end

    adb_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (emit),
        .load_data  (result),
        .load_ready (out_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // low nibble is only ever pending on a held, primed data byte
    a_phase_primed: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (hold_valid_reg && primed_reg && !is_restart))
        else $error("low nibble pending without a primed data byte");

    // high nibble result is followed by a non-final transfer in the result register
    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !item_done) |=> (m_tvalid && !m_tlast && phase_reg))
        else $error("first nibble result lost or marked last");

    // a restart leaves the decoder unprimed
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (hold_fire && is_restart) |=> !primed_reg)
        else $error("restart did not clear primed flag");

    // empty holding register always accepts
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !hold_valid_reg |-> s_tready)
        else $error("input stalled with empty holding register");

endmodule

`default_nettype wire

@@ rtl/core/adb_nib_dec.sv @@
// Combinational decode of one ADPCM nibble: table lookup, add and clamp.
// Depends on adb_pkg for the delta and next-step tables.
`default_nettype none

module adb_nib_dec (
    input  wire logic [adb_pkg::SAMPLE_W-1:0] ref_sample,
    input  wire logic [adb_pkg::STEP_W-1:0]   step,
    input  wire logic [adb_pkg::NIB_W-1:0]    nibble,
    output logic      [adb_pkg::SAMPLE_W-1:0] sample,
    output logic      [adb_pkg::STEP_W-1:0]   step_next
);

    logic [adb_pkg::IDX_W-1:0]        idx;
    logic signed [adb_pkg::SUM_W-1:0] sum;

    assign idx       = {step, nibble};
    assign step_next = adb_pkg::NEXT_TAB[idx];

    always_comb begin
        sum = $signed({2'b00, ref_sample})
            + adb_pkg::SUM_W'(adb_pkg::DELTA_TAB[idx]);
        if (sum < 0) begin
            sample = '0;
        end else if (sum > $signed({2'b00, adb_pkg::SAMPLE_MAX})) begin
            sample = adb_pkg::SAMPLE_MAX;
        end else begin
            sample = sum[adb_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/adb_out_reg.sv @@
// Output register of the result stream; loads when empty or when the held result transfers.
// Depends on adb_pkg for result_t.
`default_nettype none

module adb_out_reg (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         load_valid,
    input  wire adb_pkg::result_t             load_data,
    output logic                              load_ready,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [adb_pkg::SAMPLE_W-1:0]      m_tdata,   // [7:0] sample
    output logic                              m_tlast
);

    logic             valid_reg;
    logic             valid_next;
    adb_pkg::result_t data_reg;

    assign load_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load_valid && load_ready) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid && load_ready) begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg.sample;
    assign m_tlast  = data_reg.last;

endmodule

`default_nettype wire

@@ bench/tb_adpcm4_byte_decoder_unit.sv @@
// Self-checking bench for adpcm4_byte_decoder_unit: directed and random byte streams
// on s_*, a scoreboard class that decodes the same stream and checks every m_* transfer.
// Depends on adb_pkg (result type, func codes, sample constants) and the RTL top level.

module tb_adpcm4_byte_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;  // cycles without any transfer
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int DRAIN_WAIT  = 10;
    localparam int N_ITEMS     = 1050;

    // Decoder state mirror plus queue of samples still owed on m_*.
    class adpcm_scoreboard;
        logic [adb_pkg::SAMPLE_W-1:0] ref_smp;
        logic [adb_pkg::STEP_W-1:0]   step;
        bit                           primed;
        adb_pkg::result_t             owed_q[$];
        int errors;
        int n_in;
        int n_restart;
        int n_out;
        int n_clamp;

        function new();
            ref_smp = adb_pkg::SAMPLE_MID;
            step    = adb_pkg::STEP_INIT;
            primed  = 1'b0;
        endfunction

        // delta magnitude is ((2m+1) << step) >> 1, sign in nibble bit 3
        function void decode_nib(logic [adb_pkg::NIB_W-1:0] nib, logic lst);
            int m;
            int mag;
            int sum;
            adb_pkg::result_t r;
            m   = nib[2:0];
            mag = ((2 * m + 1) << step) >> 1;
            sum = int'(ref_smp) + (nib[3] ? -mag : mag);
            if (sum < 0) begin
                sum = 0;
                n_clamp++;
            end else if (sum > int'(adb_pkg::SAMPLE_MAX)) begin
                sum = adb_pkg::SAMPLE_MAX;
                n_clamp++;
            end
            ref_smp = sum[adb_pkg::SAMPLE_W-1:0];
            if (m == 0) begin
                if (step != 0) step = step - 1'b1;
            end else if (m >= 5) begin
                if (step != 2'd3) step = step + 1'b1;
            end
            r.sample = ref_smp;
            r.last   = lst;
            owed_q.push_back(r);
        endfunction

        function void note_input(logic fn, logic [adb_pkg::SAMPLE_W-1:0] b);
            adb_pkg::result_t r;
            n_in++;
            if (fn == adb_pkg::FUNC_RESTART) begin
                primed = 1'b0;
                n_restart++;
            end else if (!primed) begin
                primed   = 1'b1;
                ref_smp  = b;
                step     = adb_pkg::STEP_INIT;
                r.sample = b;
                r.last   = 1'b1;
                owed_q.push_back(r);
            end else begin
                decode_nib(b[7:4], 1'b0);
                decode_nib(b[3:0], 1'b1);
            end
        endfunction

        function void check_result(logic [adb_pkg::SAMPLE_W-1:0] smp, logic lst);
            adb_pkg::result_t e;
            n_out++;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got sample %0d last %0b",
                         $time, smp, lst);
                errors++;
                return;
            end
            e = owed_q.pop_front();
            if (smp !== e.sample) begin
                $display("%0t: sample mismatch, expected %0d, got %0d", $time, e.sample, smp);
                errors++;
            end
            if (lst !== e.last) begin
                $display("%0t: tlast mismatch, expected %0b, got %0b", $time, e.last, lst);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void close();
            adb_pkg::result_t e;
            while (owed_q.size() != 0) begin
                e = owed_q.pop_front();
                $display("%0t: missing result, expected sample %0d last %0b, got nothing",
                         $time, e.sample, e.last);
                errors++;
            end
        endfunction
    endclass

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [adb_pkg::SAMPLE_W-1:0] s_tdata  = '0;   // [7:0] in_byte
    logic                         s_tuser  = 1'b0; // [0] func
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [adb_pkg::SAMPLE_W-1:0] m_tdata;         // [7:0] sample
    logic                         m_tlast;

    adpcm_scoreboard sb = new();

    int  in_xfers    = 0;
    int  idle_cycles = 0;
    int  burst_left  = 0;
    int  sent        = 0;
    bit  hold_req    = 1'b0;
    int  holds_done  = 0;

    always #4 aclk = ~aclk;

    adpcm4_byte_decoder_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Input transfers are booked before outputs of the same edge are checked.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_input(s_tuser, s_tdata);
                in_xfers++;
            end
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Receiver: random stall modes in phases, plus one long hold-off on request.
    initial begin
        int mode;
        int phase_left;
        int k;
        int cnt;
        phase_left = 0;
        mode = 0;
        k = 3;
        cnt = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
                holds_done++;
            end else begin
                if (phase_left == 0) begin
                    mode = $urandom_range(0, 4);
                    phase_left = $urandom_range(16, 200);
                    k = $urandom_range(2, 5);
                end
                phase_left--;
                cnt++;
                case (mode)
                    0: m_tready = 1'b1;
                    1: m_tready = 1'($urandom_range(0, 1));
                    2: m_tready = ($urandom_range(0, 9) != 0);
                    3: m_tready = ($urandom_range(0, 4) == 0);
                    default: m_tready = ((cnt % k) != 0);
                endcase
            end
        end
    end

    // One transfer on s_*; bursts of random length separated by random gaps.
    task automatic send_xfer(input logic fn, input logic [adb_pkg::SAMPLE_W-1:0] b);
        int gap;
        int r;
        int seen;
        if (burst_left == 0) begin
            r = $urandom_range(0, 9);
            if (r < 4)      gap = 0;
            else if (r < 8) gap = $urandom_range(1, 4);
            else            gap = $urandom_range(5, 20);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                s_tdata  = adb_pkg::SAMPLE_W'($urandom);
                s_tuser  = 1'($urandom);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = fn;
        seen = in_xfers;
        wait (in_xfers != seen);
        sent++;
        if (sent == 350) hold_req = 1'b1;
    endtask

    function automatic logic [adb_pkg::SAMPLE_W-1:0] pick_byte();
        logic [adb_pkg::SAMPLE_W-1:0] edge_vals [6] = '{8'h00, 8'hFF, 8'h77, 8'h88,
                                                         8'hF7, 8'h7F};
        if ($urandom_range(0, 5) == 0)
            return edge_vals[$urandom_range(0, 5)];
        return adb_pkg::SAMPLE_W'($urandom_range(0, 255));
    endfunction

    // Restart, raw seed byte, then a run of packed bytes.
    task automatic send_stream(input int n);
        send_xfer(adb_pkg::FUNC_RESTART, adb_pkg::SAMPLE_W'($urandom_range(0, 255)));
        send_xfer(adb_pkg::FUNC_DATA, pick_byte());
        repeat (n) send_xfer(adb_pkg::FUNC_DATA, pick_byte());
    endtask

    initial begin
        int n;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // first byte after reset is raw; then drive low into the floor
        send_xfer(adb_pkg::FUNC_DATA, 8'h00);
        send_xfer(adb_pkg::FUNC_DATA, 8'hFF);
        // raw 255 then ramp up past the ceiling
        send_xfer(adb_pkg::FUNC_RESTART, 8'hA5);
        send_xfer(adb_pkg::FUNC_DATA, 8'hFF);
        send_xfer(adb_pkg::FUNC_DATA, 8'h77);
        send_xfer(adb_pkg::FUNC_DATA, 8'h77);
        // mid-scale seed, every nibble value, step up then back down
        send_xfer(adb_pkg::FUNC_RESTART, 8'h5A);
        send_xfer(adb_pkg::FUNC_DATA, 8'h80);
        send_xfer(adb_pkg::FUNC_DATA, 8'h01);
        send_xfer(adb_pkg::FUNC_DATA, 8'h23);
        send_xfer(adb_pkg::FUNC_DATA, 8'h45);
        send_xfer(adb_pkg::FUNC_DATA, 8'h67);
        send_xfer(adb_pkg::FUNC_DATA, 8'h89);
        send_xfer(adb_pkg::FUNC_DATA, 8'hAB);
        send_xfer(adb_pkg::FUNC_DATA, 8'hCD);
        send_xfer(adb_pkg::FUNC_DATA, 8'hEF);
        send_xfer(adb_pkg::FUNC_DATA, 8'h77);
        send_xfer(adb_pkg::FUNC_DATA, 8'hFF);
        send_xfer(adb_pkg::FUNC_DATA, 8'h08);
        send_xfer(adb_pkg::FUNC_DATA, 8'h80);
        // back-to-back restarts keep reference and step, only unprime
        send_xfer(adb_pkg::FUNC_RESTART, 8'h00);
        send_xfer(adb_pkg::FUNC_RESTART, 8'hFF);
        send_xfer(adb_pkg::FUNC_DATA, 8'h55);
        send_xfer(adb_pkg::FUNC_DATA, 8'h5A);

        while (sent < N_ITEMS) begin
            if ($urandom_range(0, 4) != 0) begin
                send_stream($urandom_range(1, 40));
            end else begin
                n = $urandom_range(1, 8);
                repeat (n)
                    send_xfer(($urandom_range(0, 3) == 0) ? adb_pkg::FUNC_RESTART
                                                          : adb_pkg::FUNC_DATA,
                              pick_byte());
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        sb.close();

        $display("covered %0d input transfers (%0d restarts), %0d samples, %0d clamped",
                 sb.n_in, sb.n_restart, sb.n_out, sb.n_clamp);
        $display("random stalls on both sides, %0d long output hold-off(s)", holds_done);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/adb_pkg.sv
rtl/core/adb_nib_dec.sv
rtl/core/adb_out_reg.sv
rtl/core/adpcm4_byte_decoder_unit.sv
bench/tb_adpcm4_byte_decoder_unit.sv
